// File: hdl/gtg_pkg.sv
package gtg_pkg;

    // Number formats.
    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int ANG_FRAC     = 48;
    localparam int BEAR_SH      = ANG_FRAC - FRAC_BITS;

    // Datapath widths.
    localparam int XY_W     = 28;
    localparam int GUARD_SH = 8;
    localparam int Z_W      = 52;
    localparam int ERR_W    = 18;
    localparam int MAG_W    = ERR_W - 1;
    localparam int DIST_W   = 19;
    localparam int DPROD_W  = XY_W - 1 + 16;
    localparam int DIST_SH  = 24;
    localparam int LPROD_W  = DIST_W + 16;
    localparam int APROD_W  = MAG_W + 16;
    localparam int LIN_W    = 16;
    localparam int ANG_W    = 19;

    // Stream widths.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    localparam logic [15:0] INV_K_Q16 = 16'd39797;

    localparam logic signed [Z_W-1:0] PI_Q48 = 52'sh3243F6A8885A3;
    localparam logic signed [Z_W-1:0] PI_RND =
        (PI_Q48 + (52'sd1 <<< (BEAR_SH - 1))) >>> BEAR_SH;
    localparam logic signed [ERR_W-1:0] PI_F     = PI_RND[ERR_W-1:0];
    localparam logic signed [ERR_W-1:0] NEG_PI_F = -PI_F;
    localparam logic signed [ERR_W-1:0] TWO_PI_F = {PI_F[ERR_W-2:0], 1'b0};

    localparam logic signed [ANG_W-1:0] ANG_MAX = 19'sd262143;
    localparam logic signed [ANG_W-1:0] ANG_MIN = -19'sd262144;

    // Result status codes.
    localparam logic [2:0] ST_MOVING    = 3'd0;
    localparam logic [2:0] ST_REACHED   = 3'd1;
    localparam logic [2:0] ST_POSE_FAIL = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_IDLE      = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_GOAL_X         = 3'd0;
    localparam logic [2:0] REG_GOAL_Y         = 3'd1;
    localparam logic [2:0] REG_LINEAR_GAIN    = 3'd2;
    localparam logic [2:0] REG_ANGULAR_GAIN   = 3'd3;
    localparam logic [2:0] REG_MAX_LINEAR     = 3'd4;
    localparam logic [2:0] REG_GOAL_TOLERANCE = 3'd5;
    localparam logic [2:0] REG_HEADING_LIMIT  = 3'd6;
    localparam logic [2:0] REG_STEP_LIMIT     = 3'd7;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [15:0]        linear_gain;
        logic [15:0]        angular_gain;
        logic [15:0]        max_linear;
        logic [15:0]        goal_tolerance;
        logic [13:0]        heading_limit;
        logic [15:0]        step_limit;
    } gtg_cfg_t;

    typedef struct packed {
        logic              load;
        logic              iter;
        logic [ITER_W-1:0] iter_idx;
        logic              dist_mul;
        logic              wrap;
        logic              mul;
    } gtg_cmd_t;

    typedef struct packed {
        logic reached;
        logic in_range;
    } gtg_sts_t;

    typedef struct packed {
        logic       load;
        logic       zero;
        logic [2:0] status;
        logic       last;
    } gtg_emit_t;

    typedef logic [CORDIC_ITERS-1:0][Z_W-1:0] atan_tab_t;

    // Floor of 2^e / d by restoring long division, used only for constants.
    function automatic logic [63:0] pow2_div(input int e, input int d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], (b == e)};
            q = {q[62:0], 1'b0};
            if (r >= 64'(d)) begin
                r    = r - 64'(d);
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q48 radians: pi/4 for i = 0, else from its power series, truncating each term.
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t          t;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 n;
        int                 e;
        t = '0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (i == 0) begin
                sum = 64'(PI_Q48) >>> 2;
            end else begin
                sum = '0;
                n   = 0;
                for (e = ANG_FRAC - i; e >= 0; e = e - 2 * i) begin
                    term = $signed(pow2_div(e, 2 * n + 1));
                    if (n[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                    n = n + 1;
                end
            end
            t[i] = sum[Z_W-1:0];
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

// File: hdl/go_to_goal_heading_controller_unit.sv
// A pose that drives the robot gives its command after acceptance through 16 CORDIC
// rotations, the distance multiply, the heading wrap and the gain multiply, in that order.
// Idle and pose-failure results skip the datapath; reached ones stop at the heading wrap.
// A timeout adds a stop result after its command. The single shared CORDIC stage serves
// one pose at a time; the next is taken once the last results are loaded for output.
// Reset: synchronous active-low aresetn restores defaults, ends any run, empties the output.
module go_to_goal_heading_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Pose input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, from bit 0 up: pos_x[15:0], pos_y[31:16], yaw[46:32], zero pad [47].
    input  logic [gtg_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser, from bit 0 up: start_run[0], pose_ok[1].
    input  logic [gtg_pkg::S_TUSER_W-1:0]     s_tuser,

    // Command output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, from bit 0 up: linear_cmd[15:0], angular_cmd[34:16], zero pad [39:35].
    output logic [gtg_pkg::M_TDATA_W-1:0]     m_tdata,
    // tuser, from bit 0 up: status[2:0].
    output logic [gtg_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tlast,

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_addr,
    input  logic [15:0]                       cfg_wdata
);
    import gtg_pkg::*;

    gtg_cfg_t  cfg;
    gtg_cmd_t  cmd;
    gtg_sts_t  sts;
    gtg_emit_t emit;

    logic               out_free;
    logic [15:0]        dp_lin;
    logic signed [18:0] dp_ang;

    // The output register holds one finished result until the sink takes it.
    // The controller keeps accepting poses meanwhile and only stalls when it
    // has a new result and the register is still occupied.
    logic               m_valid_reg;
    logic [15:0]        m_lin_reg;
    logic signed [18:0] m_ang_reg;
    logic [2:0]         m_status_reg;
    logic               m_last_reg;

    assign out_free = !m_valid_reg || m_tready;

    gtg_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The controller sequences one pose at a time: it decides the idle,
    // failure, reached and timeout cases and tracks the run and step count.
    gtg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .start_run  (s_tuser[0]),
        .pose_ok    (s_tuser[1]),
        .step_limit (cfg.step_limit),
        .sts        (sts),
        .out_free   (out_free),
        .cmd        (cmd),
        .emit       (emit)
    );

    // The datapath holds the CORDIC vector and angle, the heading error and
    // the two gain products.
    gtg_datapath u_datapath (
        .aclk    (aclk),
        .cmd     (cmd),
        .cfg     (cfg),
        .pos_x   (s_tdata[15:0]),
        .pos_y   (s_tdata[31:16]),
        .yaw     (s_tdata[46:32]),
        .sts     (sts),
        .lin_cmd (dp_lin),
        .ang_cmd (dp_ang)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Stop, idle and failure results carry zero speeds.
    always_ff @(posedge aclk) begin
        if (emit.load) begin
            m_lin_reg    <= emit.zero ? '0 : dp_lin;
            m_ang_reg    <= emit.zero ? '0 : dp_ang;
            m_status_reg <= emit.status;
            m_last_reg   <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_ang_reg, m_lin_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: hdl/gtg_cfg_regs.sv
module gtg_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    output gtg_pkg::gtg_cfg_t cfg
);
    import gtg_pkg::*;

    gtg_cfg_t cfg_reg;
    gtg_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_GOAL_X:         cfg_next.goal_x         = cfg_wdata;
                REG_GOAL_Y:         cfg_next.goal_y         = cfg_wdata;
                REG_LINEAR_GAIN:    cfg_next.linear_gain    = cfg_wdata;
                REG_ANGULAR_GAIN:   cfg_next.angular_gain   = cfg_wdata;
                REG_MAX_LINEAR:     cfg_next.max_linear     = cfg_wdata;
                REG_GOAL_TOLERANCE: cfg_next.goal_tolerance = cfg_wdata;
                REG_HEADING_LIMIT:  cfg_next.heading_limit  = cfg_wdata[13:0];
                REG_STEP_LIMIT:     cfg_next.step_limit     = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x         <= 16'sd2048;
            cfg_reg.goal_y         <= 16'sd0;
            cfg_reg.linear_gain    <= 16'd3277;
            cfg_reg.angular_gain   <= 16'd6144;
            cfg_reg.max_linear     <= 16'd1229;
            cfg_reg.goal_tolerance <= 16'd328;
            cfg_reg.heading_limit  <= 14'd1229;
            cfg_reg.step_limit     <= 16'd400;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/gtg_datapath.sv
module gtg_datapath (
    input  logic                      aclk,
    input  gtg_pkg::gtg_cmd_t         cmd,
    input  gtg_pkg::gtg_cfg_t         cfg,
    input  logic signed [15:0]        pos_x,
    input  logic signed [15:0]        pos_y,
    input  logic signed [14:0]        yaw,
    output gtg_pkg::gtg_sts_t         sts,
    output logic [15:0]               lin_cmd,
    output logic signed [18:0]        ang_cmd
);
    import gtg_pkg::*;

    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic signed [14:0]      yaw_reg;
    logic [DPROD_W-1:0]      dprod_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [APROD_W-1:0]      aprod_reg;
    logic [LPROD_W-1:0]      lprod_reg;
    logic                    neg_reg;
    logic                    turn_reg;

    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    logic signed [XY_W-1:0]  x0;
    logic signed [XY_W-1:0]  y0;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [Z_W-1:0]   atan_step;
    logic [XY_W-2:0]         x_pos;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [ERR_W-1:0] bearing;
    logic [DPROD_W:0]        dprod_rnd;
    logic [DIST_W-1:0]       dist_rnd;
    logic [MAG_W-1:0]        mag;
    logic [APROD_W:0]        aprod_rnd;
    logic [APROD_W-FRAC_BITS:0] ang_mag;
    logic signed [APROD_W-FRAC_BITS+1:0] ang_s;
    logic [LPROD_W:0]        lprod_rnd;
    logic [LPROD_W-FRAC_BITS:0] lin_v;

    // Vector from robot to goal with guard bits.
    assign dx = 17'(cfg.goal_x) - 17'(pos_x);
    assign dy = 17'(cfg.goal_y) - 17'(pos_y);
    assign x0 = {{(XY_W - 17 - GUARD_SH){dx[16]}}, dx, {GUARD_SH{1'b0}}};
    assign y0 = {{(XY_W - 17 - GUARD_SH){dy[16]}}, dy, {GUARD_SH{1'b0}}};

    // One micro-rotation per cycle.
    assign xs        = x_reg >>> cmd.iter_idx;
    assign ys        = y_reg >>> cmd.iter_idx;
    assign atan_step = $signed(ATAN_TAB[cmd.iter_idx]);

    assign x_pos   = x_reg[XY_W-1] ? '0 : x_reg[XY_W-2:0];
    assign z_rnd   = (z_reg + (52'sd1 <<< (BEAR_SH - 1))) >>> BEAR_SH;
    assign bearing = z_rnd[ERR_W-1:0];

    assign dprod_rnd = {1'b0, dprod_reg} + ((DPROD_W + 1)'(1) << (DIST_SH - 1));
    assign dist_rnd  = dprod_rnd[DIST_SH +: DIST_W];

    assign sts.reached  = dist_rnd < DIST_W'(cfg.goal_tolerance);
    assign sts.in_range = !(err_reg > PI_F) && !(err_reg < NEG_PI_F);

    assign mag = err_reg[ERR_W-1] ? MAG_W'(-err_reg) : err_reg[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            yaw_reg <= yaw;
            if (x0[XY_W-1]) begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= y0[XY_W-1] ? -PI_Q48 : PI_Q48;
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        if (cmd.iter) begin
            if (!y_reg[XY_W-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_step;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_step;
            end
        end
        if (cmd.dist_mul) begin
            dprod_reg <= DPROD_W'(x_pos) * DPROD_W'(INV_K_Q16);
            err_reg   <= bearing - ERR_W'(yaw_reg);
        end
        if (cmd.wrap) begin
            dist_reg <= dist_rnd;
            if (err_reg > PI_F) begin
                err_reg <= err_reg - TWO_PI_F;
            end else if (err_reg < NEG_PI_F) begin
                err_reg <= err_reg + TWO_PI_F;
            end
        end
        if (cmd.mul) begin
            aprod_reg <= APROD_W'(mag) * APROD_W'(cfg.angular_gain);
            lprod_reg <= LPROD_W'(dist_reg) * LPROD_W'(cfg.linear_gain);
            neg_reg   <= err_reg[ERR_W-1];
            turn_reg  <= MAG_W'(cfg.heading_limit) < mag;
        end
    end

    // Turn rate: round half away from zero, then saturate.
    assign aprod_rnd = {1'b0, aprod_reg} + ((APROD_W + 1)'(1) << (FRAC_BITS - 1));
    assign ang_mag   = aprod_rnd[APROD_W:FRAC_BITS];
    assign ang_s     = neg_reg ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});

    always_comb begin
        if (ang_s > $signed((APROD_W - FRAC_BITS + 2)'(ANG_MAX))) begin
            ang_cmd = ANG_MAX;
        end else if (ang_s < $signed((APROD_W - FRAC_BITS + 2)'(ANG_MIN))) begin
            ang_cmd = ANG_MIN;
        end else begin
            ang_cmd = ang_s[ANG_W-1:0];
        end
    end

    // Forward speed: zero when the heading error exceeds the limit, else round half up, then cap.
    assign lprod_rnd = {1'b0, lprod_reg} + ((LPROD_W + 1)'(1) << (FRAC_BITS - 1));
    assign lin_v     = lprod_rnd[LPROD_W:FRAC_BITS];

    always_comb begin
        if (turn_reg) begin
            lin_cmd = '0;
        end else if (lin_v > (LPROD_W - FRAC_BITS + 1)'(cfg.max_linear)) begin
            lin_cmd = cfg.max_linear;
        end else begin
            lin_cmd = lin_v[LIN_W-1:0];
        end
    end

endmodule

// File: hdl/gtg_ctrl.sv
module gtg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               start_run,
    input  logic               pose_ok,
    input  logic [15:0]        step_limit,
    input  gtg_pkg::gtg_sts_t  sts,
    input  logic               out_free,
    output gtg_pkg::gtg_cmd_t  cmd,
    output gtg_pkg::gtg_emit_t emit
);
    import gtg_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ITER      = 3'd1;
    localparam logic [2:0] S_DIST      = 3'd2;
    localparam logic [2:0] S_WRAP      = 3'd3;
    localparam logic [2:0] S_MUL       = 3'd4;
    localparam logic [2:0] S_EMIT_CMD  = 3'd5;
    localparam logic [2:0] S_EMIT_STOP = 3'd6;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    logic [2:0]        state_reg,   state_next;
    logic [ITER_W-1:0] iter_reg,    iter_next;
    logic              running_reg, running_next;
    logic [15:0]       step_reg,    step_next;
    logic              timeout_reg, timeout_next;
    logic [2:0]        stop_reg,    stop_next;
    logic [15:0]       step_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign step_inc = step_reg + 16'd1;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        running_next = running_reg;
        step_next    = step_reg;
        timeout_next = timeout_reg;
        stop_next    = stop_reg;
        cmd          = '0;
        cmd.iter_idx = iter_reg;
        emit         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (start_run) begin
                        step_next = '0;
                    end
                    if (!(start_run || running_reg)) begin
                        stop_next  = ST_IDLE;
                        state_next = S_EMIT_STOP;
                    end else if (!pose_ok) begin
                        running_next = 1'b0;
                        stop_next    = ST_POSE_FAIL;
                        state_next   = S_EMIT_STOP;
                    end else begin
                        running_next = 1'b1;
                        cmd.load     = 1'b1;
                        iter_next    = '0;
                        state_next   = S_ITER;
                    end
                end
            end
            S_ITER: begin
                cmd.iter  = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = S_DIST;
                end
            end
            S_DIST: begin
                cmd.dist_mul = 1'b1;
                state_next   = S_WRAP;
            end
            S_WRAP: begin
                cmd.wrap = 1'b1;
                if (sts.reached) begin
                    running_next = 1'b0;
                    stop_next    = ST_REACHED;
                    state_next   = S_EMIT_STOP;
                end else if (sts.in_range) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (step_inc >= step_limit) begin
                    timeout_next = 1'b1;
                    running_next = 1'b0;
                    step_next    = '0;
                end else begin
                    timeout_next = 1'b0;
                    step_next    = step_inc;
                end
                state_next = S_EMIT_CMD;
            end
            S_EMIT_CMD: begin
                if (out_free) begin
                    emit.load   = 1'b1;
                    emit.zero   = 1'b0;
                    emit.status = ST_MOVING;
                    emit.last   = !timeout_reg;
                    if (timeout_reg) begin
                        stop_next  = ST_TIMEOUT;
                        state_next = S_EMIT_STOP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_STOP: begin
                if (out_free) begin
                    emit.load   = 1'b1;
                    emit.zero   = 1'b1;
                    emit.status = stop_reg;
                    emit.last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            iter_reg    <= '0;
            running_reg <= 1'b0;
            step_reg    <= '0;
            timeout_reg <= 1'b0;
            stop_reg    <= ST_IDLE;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            running_reg <= running_next;
            step_reg    <= step_next;
            timeout_reg <= timeout_next;
            stop_reg    <= stop_next;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gtg_pkg::*;

    // Cycle budget for the whole run. It lies far above the slowest legal run, even with
    // sender gaps and receiver stalls, so this bound only trips on a real hang.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int END_SETTLE   = 30;
    localparam int PRINT_LIMIT  = 60;

    // The controller's arithmetic constants as this bench models them.
    localparam longint PI_Q48_TB    = 64'sh3243F6A8885A3;
    localparam longint INV_GAIN_Q16 = 39797;
    localparam int     GUARD_SCALE  = 256;
    localparam int     ANGLE_SHIFT  = 48 - FRAC_BITS;
    localparam longint TURN_MAX     = 262143;
    localparam longint TURN_MIN     = -262144;

    // One pose sample as the sender sees it.
    typedef struct {
        logic               start_run;
        logic               pose_ok;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [14:0] yaw;
    } pose_sample_t;

    // One motion command as the block should produce it.
    typedef struct {
        logic [15:0]        lin;
        logic signed [18:0] ang;
        logic [2:0]         status;
        logic               last;
    } command_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_addr  = '0;
    logic [15:0]           cfg_wdata = '0;

    // Bench copy of the controller: its registers and its navigation state.
    gtg_cfg_t    nav_cfg;
    logic        nav_running;
    logic [15:0] nav_steps;

    command_t expected_cmds[$];

    int  mismatches       = 0;
    int  poses_sent       = 0;
    int  commands_checked = 0;
    int  status_seen[5]   = '{default: 0};
    int  cycles           = 0;
    // While set, neither side inserts idle cycles.
    bit  steady_flow      = 1'b0;

    go_to_goal_heading_controller_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands still expected",
                     cycles, expected_cmds.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Outside steady flow, the command receiver stalls with a chance of about 31 in a hundred.
    always @(posedge aclk) begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 31);
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] command %0d: %s", $realtime, commands_checked, msg);
    endtask

    // atan(2^-i) in Q48 radians. The series terms are truncated one by one, so the
    // table must be built the same way rather than from a real-valued atan.
    function automatic longint atan_step(int i);
        longint acc;
        int     e;
        int     n;
        if (i == 0)
            return PI_Q48_TB / 4;
        acc = 0;
        n   = 0;
        for (e = 48 - i; e >= 0; e -= 2 * i) begin
            if (n % 2 == 1)
                acc -= (longint'(1) << e) / longint'(2 * n + 1);
            else
                acc += (longint'(1) << e) / longint'(2 * n + 1);
            n++;
        end
        return acc;
    endfunction

    function automatic void queue_command(longint lin, longint ang, logic [2:0] st,
                                          logic last);
        command_t c;
        c.lin    = 16'(lin);
        c.ang    = 19'(ang);
        c.status = st;
        c.last   = last;
        expected_cmds.push_back(c);
    endfunction

    // Works out the commands one accepted pose causes and advances the bench's
    // navigation state the same way the block must.
    function automatic void predict_commands(pose_sample_t p);
        longint vx, vy, vz, xs, ys;
        longint dist_q, pi_f, bearing, err, mag, ang, speed, lin;
        if (p.start_run) begin
            nav_running = 1'b1;
            nav_steps   = '0;
        end
        if (!nav_running) begin
            queue_command(0, 0, ST_IDLE, 1'b1);
            return;
        end
        if (!p.pose_ok) begin
            nav_running = 1'b0;
            queue_command(0, 0, ST_POSE_FAIL, 1'b1);
            return;
        end

        // Vector from robot to goal, vectored onto the x axis. A vector pointing
        // backwards is flipped first and the angle starts at plus or minus pi.
        vx = (longint'(nav_cfg.goal_x) - longint'(p.pos_x)) * GUARD_SCALE;
        vy = (longint'(nav_cfg.goal_y) - longint'(p.pos_y)) * GUARD_SCALE;
        vz = 0;
        if (vx < 0) begin
            vz = (vy >= 0) ? PI_Q48_TB : -PI_Q48_TB;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys;
                vy -= xs;
                vz += atan_step(i);
            end else begin
                vx -= ys;
                vy += xs;
                vz -= atan_step(i);
            end
        end
        if (vx < 0)
            vx = 0;
        // Remove the CORDIC gain and the guard bits, rounding half up.
        dist_q = (vx * INV_GAIN_Q16 + (longint'(1) << 23)) >>> 24;

        if (dist_q < longint'(nav_cfg.goal_tolerance)) begin
            nav_running = 1'b0;
            queue_command(0, 0, ST_REACHED, 1'b1);
            return;
        end

        pi_f    = (PI_Q48_TB + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
        bearing = (vz + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
        err     = bearing - longint'(p.yaw);
        while (err > pi_f)
            err -= 2 * pi_f;
        while (err < -pi_f)
            err += 2 * pi_f;

        // Turn rate rounds half away from zero, then saturates.
        mag = (err < 0) ? -err : err;
        ang = (mag * longint'(nav_cfg.angular_gain) + (longint'(1) << (FRAC_BITS - 1)))
              >>> FRAC_BITS;
        if (err < 0)
            ang = -ang;
        if (ang > TURN_MAX)
            ang = TURN_MAX;
        if (ang < TURN_MIN)
            ang = TURN_MIN;

        // Large heading error turns in place; otherwise drive at a capped speed.
        if (mag > longint'(nav_cfg.heading_limit)) begin
            lin = 0;
        end else begin
            speed = (dist_q * longint'(nav_cfg.linear_gain)
                     + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            lin = (speed > longint'(nav_cfg.max_linear)) ? longint'(nav_cfg.max_linear)
                                                          : speed;
        end

        nav_steps = nav_steps + 16'd1;
        if (nav_steps >= nav_cfg.step_limit) begin
            nav_running = 1'b0;
            nav_steps   = '0;
            queue_command(lin, ang, ST_MOVING, 1'b0);
            queue_command(0, 0, ST_TIMEOUT, 1'b1);
        end else begin
            queue_command(lin, ang, ST_MOVING, 1'b1);
        end
    endfunction

    // Every accepted command is compared against the oldest expectation.
    always @(posedge aclk) begin : check_commands
        command_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected command, status %0d lin %0d ang %0d",
                                          m_tuser, m_tdata[15:0],
                                          $signed(m_tdata[34:16])));
            end else begin
                want = expected_cmds.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status is %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast is %b, expected %b",
                                              m_tlast, want.last));
                if (m_tdata[15:0] !== want.lin)
                    report_mismatch($sformatf("linear_cmd is %0d, expected %0d",
                                              m_tdata[15:0], want.lin));
                if (m_tdata[34:16] !== want.ang)
                    report_mismatch($sformatf("angular_cmd is %0d, expected %0d",
                                              $signed(m_tdata[34:16]), want.ang));
                if (want.status <= ST_IDLE)
                    status_seen[want.status]++;
            end
            commands_checked++;
        end
    end

    // Writes one register and leaves cfg_valid high; apply_settings drops it.
    task automatic write_register(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GOAL_X:         nav_cfg.goal_x         = value;
            REG_GOAL_Y:         nav_cfg.goal_y         = value;
            REG_LINEAR_GAIN:    nav_cfg.linear_gain    = value;
            REG_ANGULAR_GAIN:   nav_cfg.angular_gain   = value;
            REG_MAX_LINEAR:     nav_cfg.max_linear     = value;
            REG_GOAL_TOLERANCE: nav_cfg.goal_tolerance = value;
            REG_HEADING_LIMIT:  nav_cfg.heading_limit  = value[13:0];
            REG_STEP_LIMIT:     nav_cfg.step_limit     = value;
            default: ;
        endcase
    endtask

    // Only called while the controller is idle.
    task automatic apply_settings(gtg_cfg_t c);
        write_register(REG_GOAL_X, c.goal_x);
        write_register(REG_GOAL_Y, c.goal_y);
        write_register(REG_LINEAR_GAIN, c.linear_gain);
        write_register(REG_ANGULAR_GAIN, c.angular_gain);
        write_register(REG_MAX_LINEAR, c.max_linear);
        write_register(REG_GOAL_TOLERANCE, c.goal_tolerance);
        write_register(REG_HEADING_LIMIT, 16'(c.heading_limit));
        write_register(REG_STEP_LIMIT, c.step_limit);
        cfg_valid <= 1'b0;
    endtask

    // Sends one pose. tvalid stays high afterwards unless a random gap follows, so
    // back-to-back poses need no extra assignment in the same step.
    task automatic send_pose(pose_sample_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, p.yaw, p.pos_y, p.pos_x};
        s_tuser  <= {p.pose_ok, p.start_run};
        do @(posedge aclk); while (!s_tready);
        predict_commands(p);
        poses_sent++;
        if (!steady_flow && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 40 : 6)) @(posedge aclk);
        end
    endtask

    // Holds the pose stream until every outstanding command has been received.
    // It always waits on a clock edge, so the caller's next drive of
    // tvalid lands in a later time step.
    task automatic wait_for_commands();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_cmds.size() != 0);
    endtask

    function automatic pose_sample_t make_pose(bit start, bit ok, int x, int y, int yaw);
        pose_sample_t p;
        p.start_run = start;
        p.pose_ok   = ok;
        p.pos_x     = 16'(x);
        p.pos_y     = 16'(y);
        p.yaw       = 15'(yaw);
        return p;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic gtg_cfg_t reset_settings();
        gtg_cfg_t c;
        c.goal_x         = 16'sd2048;
        c.goal_y         = 16'sd0;
        c.linear_gain    = 16'd3277;
        c.angular_gain   = 16'd6144;
        c.max_linear     = 16'd1229;
        c.goal_tolerance = 16'd328;
        c.heading_limit  = 14'd1229;
        c.step_limit     = 16'd400;
        return c;
    endfunction

    function automatic gtg_cfg_t random_settings();
        gtg_cfg_t c;
        int       pick;
        c.goal_x       = ($urandom_range(1) == 0) ? 16'($urandom_range(16383)) - 16'sd8192
                                                  : 16'($urandom());
        c.goal_y       = ($urandom_range(1) == 0) ? 16'($urandom_range(16383)) - 16'sd8192
                                                  : 16'($urandom());
        c.linear_gain  = 16'($urandom());
        c.angular_gain = 16'($urandom());
        c.max_linear   = 16'($urandom());
        c.goal_tolerance = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(50, 1500));
        c.heading_limit  = 14'($urandom_range(12868));
        pick = $urandom_range(9);
        if (pick <= 4)
            c.step_limit = 16'($urandom_range(1, 10));
        else if (pick == 5)
            c.step_limit = 16'd0;
        else if (pick == 6)
            c.step_limit = 16'hFFFF;
        else
            c.step_limit = 16'($urandom_range(20, 400));
        return c;
    endfunction

    // One navigation run: the robot approaches the goal along a straight line and
    // the last sample lies within 32 of the goal on each axis. Some samples fail, some
    // restart the run, and a stray sample with random fields may follow the run.
    task automatic drive_random_run();
        int           n, scale, ox, oy, jx, jy, yaw;
        pose_sample_t p;
        n = $urandom_range(1, 12);
        case ($urandom_range(3))
            0: scale = 400;
            1: scale = 4000;
            2: scale = 20000;
            default: scale = 65535;
        endcase
        ox = int'($urandom_range(2 * scale)) - scale;
        oy = int'($urandom_range(2 * scale)) - scale;
        for (int k = 0; k < n; k++) begin
            jx  = int'($urandom_range(64)) - 32;
            jy  = int'($urandom_range(64)) - 32;
            yaw = ($urandom_range(9) == 0) ? int'($urandom())
                                           : int'($urandom_range(25736)) - 12868;
            p = make_pose((k == 0) || ($urandom_range(99) < 4),
                          $urandom_range(99) >= 5,
                          clamp16(int'(nav_cfg.goal_x) + ox * (n - 1 - k) / n + jx),
                          clamp16(int'(nav_cfg.goal_y) + oy * (n - 1 - k) / n + jy),
                          yaw);
            send_pose(p);
        end
        if ($urandom_range(99) < 30)
            send_pose(make_pose(1'b0, $urandom_range(1), int'($urandom()),
                                int'($urandom()), int'($urandom())));
    endtask

    // Reset values: idle output, plain runs, every way a run ends but timeout,
    // restarts, yaw outside plus or minus pi, and the goal under the robot.
    task automatic test_default_runs();
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b1, -32768, -32768, 0));
        send_pose(make_pose(1'b0, 1'b1, 32767, 32767, -12868));
        send_pose(make_pose(1'b0, 1'b1, 2000, 10, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b0, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b1, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b1, 0, 0, 12868));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 16383));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, -16384));
        send_pose(make_pose(1'b0, 1'b1, 2048, 0, 0));
        wait_for_commands();
    endtask

    // Register extremes: goals at the corners, full-scale gains and cap, a zero
    // tolerance that never reaches (even with the goal under the robot), heading limits
    // of zero and pi, and the smallest and largest step limits.
    task automatic test_register_extremes();
        gtg_cfg_t c;
        c = '{goal_x: -16'sd32768, goal_y: 16'sd32767, linear_gain: 16'hFFFF,
              angular_gain: 16'hFFFF, max_linear: 16'hFFFF, goal_tolerance: 16'd0,
              heading_limit: 14'd12868, step_limit: 16'hFFFF};
        apply_settings(c);
        send_pose(make_pose(1'b1, 1'b1, 32767, -32768, 12868));
        send_pose(make_pose(1'b0, 1'b1, -32768, 32767, -12868));
        wait_for_commands();

        c = '{goal_x: 16'sd32767, goal_y: -16'sd32768, linear_gain: 16'd0,
              angular_gain: 16'd0, max_linear: 16'd0, goal_tolerance: 16'hFFFF,
              heading_limit: 14'd0, step_limit: 16'd0};
        apply_settings(c);
        send_pose(make_pose(1'b1, 1'b1, -32768, 32767, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0));
        wait_for_commands();
    endtask

    // The step limit: a limit of one times out on every pose, a limit of three
    // times out on the third, and a restart clears the count.
    task automatic test_step_limit();
        gtg_cfg_t c;
        c = reset_settings();
        c.step_limit = 16'd1;
        apply_settings(c);
        send_pose(make_pose(1'b1, 1'b1, 0, 0, 0));
        wait_for_commands();

        c.step_limit = 16'd3;
        apply_settings(c);
        send_pose(make_pose(1'b1, 1'b1, -4096, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, -4000, 100, 100));
        send_pose(make_pose(1'b0, 1'b1, -3900, 200, -200));
        send_pose(make_pose(1'b1, 1'b1, -4096, 4096, 0));
        send_pose(make_pose(1'b1, 1'b1, -4096, 4096, 0));
        send_pose(make_pose(1'b0, 1'b1, -2048, -4096, 3000));
        send_pose(make_pose(1'b0, 1'b1, -1024, -2048, -3000));
        wait_for_commands();
    endtask

    // Random runs under several random settings. One phase runs with no idling on
    // either side, and every phase pauses once mid-stream until it drains.
    task automatic test_random_navigation();
        int target;
        bit drained;
        for (int phase = 0; phase < 6; phase++) begin
            steady_flow = (phase == 2);
            apply_settings(random_settings());
            target  = poses_sent + 68;
            drained = 1'b0;
            while (poses_sent < target) begin
                drive_random_run();
                if (!drained && poses_sent >= target - 34) begin
                    wait_for_commands();
                    drained = 1'b1;
                end
            end
            wait_for_commands();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        nav_cfg     = reset_settings();
        nav_running = 1'b0;
        nav_steps   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_runs();
        test_register_extremes();
        test_step_limit();
        test_random_navigation();

        wait_for_commands();
        repeat (END_SETTLE) @(posedge aclk);
        // Any expectation still waiting counts as a failure.
        mismatches += expected_cmds.size();

        $display("sent %0d poses and checked %0d commands over %0d cycles",
                 poses_sent, commands_checked, cycles);
        $display("commands by status: moving %0d, reached %0d, pose failed %0d, "
                 , status_seen[ST_MOVING], status_seen[ST_REACHED],
                 status_seen[ST_POSE_FAIL], "timeout %0d, idle %0d; mismatches %0d",
                 status_seen[ST_TIMEOUT], status_seen[ST_IDLE], mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
